### design/gfpa_pkg.sv
// shared types and constants of the growable fifo page allocator
`timescale 1ns / 1ps
`default_nettype none

package gfpa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_BYTES = 4096;

  // fixed field widths
  localparam int PAGE_FW   = 10;
  localparam int PROT_FW   = 2;
  localparam int OFFSET_FW = 22;
  localparam int STATUS_FW = 2;
  localparam int CFG_W     = 11;

  // derived widths
  localparam int RING_AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int PB_W    = $clog2(PAGE_BYTES + 1);
  localparam int GROW_W  = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

  localparam logic [CFG_W-1:0] INITIAL_PAGES_RST = CFG_W'(256);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_FW-1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_PAGES = 2'd1,
    ST_BAD_PAGE     = 2'd2
  } status_t;

  typedef enum logic {
    BK_EXEC   = 1'b0,
    BK_RDWAIT = 1'b1
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic [PAGE_FW-1:0] page_number;
    logic [PROT_FW-1:0] prot_req;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_FW-1:0]   page_number_out;
    logic [OFFSET_FW-1:0] byte_offset;
    logic                 grew;
    logic                 apply_protect;
    status_t              status;
  } out_item_t;

  // classified request as queued between front and back
  typedef struct packed {
    logic               is_free;
    logic [PAGE_FW-1:0] page;
    logic               want_write;
  } req_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_out_t;

endpackage

`default_nettype wire

### design/growable_fifo_page_allocator_top.sv
// top level of the growable fifo page allocator
// Usage:
//   in_valid/in_stall/in_data carry requests: allocate (oldest never-used
//   page first, then the oldest freed page) or free (append to the ring).
//   out_valid/out_stall/out_data return one result per request, in order,
//   with page number, byte offset, grow flag, write-protect flag and status.
//   cfg_we/cfg_wdata write the initial pool size, taken on first growth.
// Path: a request waits in the two-entry input queue until the back end
//   pops it; a free or fresh-page allocate is then written to the result
//   register, while an allocate from the freed-page ring first passes the
//   registered ring memory read in the read-wait state.
// Throughput: one transaction per cycle while out_stall does not hold a result,
//   except ring allocates, which hold the back end in the read-wait state.
// Reset: rst_n clears the pool, the ring pointers and counters and sets the
//   initial pool size to 256; the ring contents need no clearing.
// Stall: while out_stall holds a result, the back end stops and the input
//   queue fills; in_stall rises once both queue entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module growable_fifo_page_allocator_top
  import gfpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  queue_out_t q_link;
  logic       q_pop;

  gfpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_out    (q_link),
    .q_pop    (q_pop)
  );

  gfpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_in      (q_link),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### design/gfpa_front.sv
// front end: accepts requests, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module gfpa_front
  import gfpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output queue_out_t      q_out,
  input  wire logic       q_pop
);

  req_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  req_t       req_in;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count_r != 2'd0);

  always_comb begin
    req_in.is_free    = (in_data.op == OP_FREE);
    req_in.page       = in_data.page_number;
    req_in.want_write = in_data.prot_req[1];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req_in;
    end
  end

  assign q_out.valid = (count_r != 2'd0);
  assign q_out.req   = q_mem_r[rd_ptr_r];

endmodule

`default_nettype wire

### design/gfpa_back.sv
// back end: pool growth, free ring memory and the result register
`timescale 1ns / 1ps
`default_nettype none

module gfpa_back
  import gfpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire queue_out_t       q_in,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic [PAGE_FW-1:0] ring_mem [MAX_PAGES];
  logic [PAGE_FW-1:0] rd_data_r;

  bk_state_t          state_r, state_nxt;
  logic [CFG_W-1:0]   initial_pages_r;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [RING_AW-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]   free_count_r, free_count_nxt;
  logic [CNT_W-1:0]   fresh_next_r, fresh_next_nxt;
  logic [CNT_W-1:0]   pool_pages_r, pool_pages_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               pend_protect_r, pend_protect_nxt;

  logic               out_free;
  logic               ring_we;
  logic               ring_re;
  logic               need_grow;
  logic               bad_free;
  logic [GROW_W-1:0]  t_wide;
  logic [CNT_W-1:0]   grow_t;
  logic [CNT_W-1:0]   pool_eff;

  function automatic logic [RING_AW-1:0] ring_adv(input logic [RING_AW-1:0] pos);
    logic [RING_AW-1:0] r;
    if (pos == RING_AW'(MAX_PAGES - 1)) r = '0;
    else r = pos + RING_AW'(1);
    return r;
  endfunction

  function automatic logic [OFFSET_FW-1:0] page_offset(input logic [PAGE_FW-1:0] pg);
    logic [PAGE_FW+PB_W-1:0] prod;
    prod = (PAGE_FW+PB_W)'(pg) * (PAGE_FW+PB_W)'(PAGE_BYTES);
    return OFFSET_FW'(prod);
  endfunction

  // growth target: initial size (zero counts as one) on first growth, doubling after, clamped
  always_comb begin
    if (pool_pages_r == '0) begin
      if (initial_pages_r == '0) t_wide = GROW_W'(1);
      else t_wide = GROW_W'(initial_pages_r);
    end else begin
      t_wide = GROW_W'({pool_pages_r, 1'b0});
    end
    if (t_wide > GROW_W'(MAX_PAGES)) t_wide = GROW_W'(MAX_PAGES);
    grow_t = CNT_W'(t_wide);
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign need_grow = (fresh_next_r >= pool_pages_r) && (free_count_r == '0);
  assign bad_free  = (CNT_W'(q_in.req.page) >= pool_pages_r) ||
                     (free_count_r >= CNT_W'(MAX_PAGES));
  assign pool_eff  = need_grow ? grow_t : pool_pages_r;

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    free_count_nxt   = free_count_r;
    fresh_next_nxt   = fresh_next_r;
    pool_pages_nxt   = pool_pages_r;
    pend_protect_nxt = pend_protect_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    q_pop            = 1'b0;
    ring_we          = 1'b0;
    ring_re          = 1'b0;

    unique case (state_r)
      BK_EXEC: begin
        if (q_in.valid && out_free) begin
          q_pop                        = 1'b1;
          out_data_nxt.page_number_out = '0;
          out_data_nxt.byte_offset     = '0;
          out_data_nxt.grew            = 1'b0;
          out_data_nxt.apply_protect   = 1'b0;
          out_data_nxt.status          = ST_OK;
          if (q_in.req.is_free) begin
            out_valid_nxt = 1'b1;
            if (bad_free) begin
              out_data_nxt.status = ST_BAD_PAGE;
            end else begin
              ring_we        = 1'b1;
              tail_nxt       = ring_adv(tail_r);
              free_count_nxt = free_count_r + CNT_W'(1);
            end
          end else if (need_grow && !(grow_t > pool_pages_r)) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_OUT_OF_PAGES;
          end else begin
            pool_pages_nxt = pool_eff;
            if (fresh_next_r < pool_eff) begin
              out_valid_nxt                = 1'b1;
              fresh_next_nxt               = fresh_next_r + CNT_W'(1);
              out_data_nxt.page_number_out = PAGE_FW'(fresh_next_r);
              out_data_nxt.byte_offset     = page_offset(PAGE_FW'(fresh_next_r));
              out_data_nxt.grew            = need_grow;
              out_data_nxt.apply_protect   = q_in.req.want_write;
            end else begin
              // oldest freed page: registered ring read, result given in the read-wait state
              ring_re          = 1'b1;
              head_nxt         = ring_adv(head_r);
              free_count_nxt   = free_count_r - CNT_W'(1);
              pend_protect_nxt = q_in.req.want_write;
              state_nxt        = BK_RDWAIT;
            end
          end
        end
      end
      BK_RDWAIT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.page_number_out = rd_data_r;
          out_data_nxt.byte_offset     = page_offset(rd_data_r);
          out_data_nxt.grew            = 1'b0;
          out_data_nxt.apply_protect   = pend_protect_r;
          out_data_nxt.status          = ST_OK;
          state_nxt                    = BK_EXEC;
        end
      end
      default: state_nxt = BK_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= BK_EXEC;
      initial_pages_r <= INITIAL_PAGES_RST;
      head_r          <= '0;
      tail_r          <= '0;
      free_count_r    <= '0;
      fresh_next_r    <= '0;
      pool_pages_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_count_r <= free_count_nxt;
      fresh_next_r <= fresh_next_nxt;
      pool_pages_r <= pool_pages_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        initial_pages_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r     <= out_data_nxt;
    pend_protect_r <= pend_protect_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[tail_r] <= q_in.req.page;
    end
    if (ring_re) begin
      rd_data_r <= ring_mem[head_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= CNT_W'(MAX_PAGES))
    else $error("free count exceeds ring depth");

  a_fresh_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_next_r <= pool_pages_r)
    else $error("fresh page pointer beyond pool");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pool_pages_r <= CNT_W'(MAX_PAGES))
    else $error("pool beyond capacity");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ring_re |=> (state_r == BK_RDWAIT) && !out_valid_r || out_stall)
    else $error("ring read not followed by wait state");

  a_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_EXEC) && q_in.valid)
    else $error("queue popped outside execute state");

endmodule

`default_nettype wire

### verif/growable_fifo_page_allocator_top_test.sv
// self-checking testbench of the growable fifo page allocator top level
`timescale 1ns / 1ps

module growable_fifo_page_allocator_top_test;
  import gfpa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [PROT_FW-1:0] PROT_READ_ONLY = 2'b01;

  typedef struct {
    in_item_t  req;
    bit        fixed;
    out_item_t res;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  growable_fifo_page_allocator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator state as the block should hold it
  logic [PAGE_FW-1:0] ring_mem [MAX_PAGES];
  logic [PROT_FW-1:0] page_prot [MAX_PAGES];
  logic [RING_AW-1:0] ring_rd;
  logic [RING_AW-1:0] ring_wr;
  logic [CNT_W-1:0]   free_cnt;
  logic [CNT_W-1:0]   fresh_next;
  logic [CNT_W-1:0]   pool_pages;
  logic [CFG_W-1:0]   init_pages;

  out_item_t          results_due[$];
  logic [PAGE_FW-1:0] held_pages[$];
  plan_row_t          plan[$];

  int  fail_count;
  int  oop_hits;
  int  cycle_count;
  bit  idle_on;
  int  burst_left;
  int  rx_tick;
  int  rx_run;

  task automatic serve_request(input in_item_t rq, output out_item_t rs);
    int                 target;
    logic [PAGE_FW-1:0] pg;
    rs = '0;
    rs.status = ST_OK;
    if (rq.op == OP_FREE) begin
      if (rq.page_number >= pool_pages || free_cnt >= MAX_PAGES) begin
        rs.status = ST_BAD_PAGE;
      end else begin
        ring_mem[ring_wr] = rq.page_number;
        ring_wr = (ring_wr == RING_AW'(MAX_PAGES - 1)) ? '0 : ring_wr + 1'b1;
        free_cnt = free_cnt + 1'b1;
      end
    end else begin
      if (fresh_next >= pool_pages && free_cnt == 0) begin
        // counter-based growth: first to the register value, then doubling
        if (pool_pages == 0) target = (init_pages == 0) ? 1 : int'(init_pages);
        else target = 2 * int'(pool_pages);
        if (target > MAX_PAGES) target = MAX_PAGES;
        if (target > int'(pool_pages)) begin
          pool_pages = CNT_W'(target);
          rs.grew = 1'b1;
        end else begin
          rs.status = ST_OUT_OF_PAGES;
        end
      end
      if (rs.status == ST_OK) begin
        if (fresh_next < pool_pages) begin
          pg = fresh_next[PAGE_FW-1:0];
          fresh_next = fresh_next + 1'b1;
        end else begin
          pg = ring_mem[ring_rd];
          ring_rd = (ring_rd == RING_AW'(MAX_PAGES - 1)) ? '0 : ring_rd + 1'b1;
          free_cnt = free_cnt - 1'b1;
        end
        page_prot[pg] = rq.prot_req;
        rs.page_number_out = pg;
        rs.byte_offset = OFFSET_FW'(int'(pg) * PAGE_BYTES);
        rs.apply_protect = rq.prot_req[1];
        rs.grew = rs.grew;
      end else begin
        rs.grew = 1'b0;
      end
    end
  endtask

  task automatic send_request(input in_item_t rq, input bit fixed, input out_item_t fixed_res);
    out_item_t res;
    if (idle_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    serve_request(rq, res);
    if (rq.op == OP_ALLOC && res.status == ST_OK) held_pages.push_back(res.page_number_out);
    if (res.status == ST_OUT_OF_PAGES) oop_hits++;
    results_due.push_back(fixed ? fixed_res : res);
  endtask

  task automatic pick_request(input int alloc_pct, output in_item_t rq);
    int idx;
    rq.page_number = PAGE_FW'($urandom_range(0, MAX_PAGES - 1));
    rq.prot_req    = PROT_FW'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < alloc_pct) begin
      rq.op = OP_ALLOC;
    end else begin
      rq.op = OP_FREE;
      // mostly give back a page that is out, otherwise any page number
      if (held_pages.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, held_pages.size() - 1);
        rq.page_number = held_pages[idx];
        held_pages.delete(idx);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_initial_pages(input logic [CFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    init_pages = value;
  endtask

  task automatic add_row(input op_t op, input int pg, input int prot, input bit fixed,
                         input int epg, input int eoff, input bit egrew, input bit eprot,
                         input status_t est);
    plan_row_t row;
    row.req.op               = op;
    row.req.page_number      = PAGE_FW'(pg);
    row.req.prot_req         = PROT_FW'(prot);
    row.fixed                = fixed;
    row.res.page_number_out  = PAGE_FW'(epg);
    row.res.byte_offset      = OFFSET_FW'(eoff);
    row.res.grew             = egrew;
    row.res.apply_protect    = eprot;
    row.res.status           = est;
    plan.push_back(row);
  endtask

  // receiver stall pattern: quiet, light random, long runs, alternating
  always @(posedge clk) begin : rx_pattern
    logic nxt;
    case ((rx_tick / 150) % 4)
      0: nxt = 1'b0;
      1: nxt = ($urandom_range(0, 3) == 0);
      2: begin
        if (rx_run > 0) begin
          rx_run--;
          nxt = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_run = $urandom_range(1, 9);
          nxt = 1'b1;
        end else begin
          nxt = 1'b0;
        end
      end
      default: nxt = rx_tick[0];
    endcase
    rx_tick++;
    out_stall <= nxt;
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: page %0d status %0d",
               out_data.page_number_out, out_data.status);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data.page_number_out !== want.page_number_out) begin
          $error("page_number_out expected %0d actual %0d",
                 want.page_number_out, out_data.page_number_out);
          fail_count++;
        end
        if (out_data.byte_offset !== want.byte_offset) begin
          $error("byte_offset expected %0d actual %0d", want.byte_offset, out_data.byte_offset);
          fail_count++;
        end
        if (out_data.grew !== want.grew) begin
          $error("grew expected %0d actual %0d", want.grew, out_data.grew);
          fail_count++;
        end
        if (out_data.apply_protect !== want.apply_protect) begin
          $error("apply_protect expected %0d actual %0d",
                 want.apply_protect, out_data.apply_protect);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : main_flow
    in_item_t rq;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    fail_count = 0;
    oop_hits = 0;
    cycle_count = 0;
    rx_tick = 0;
    rx_run = 0;
    idle_on = 1'b1;
    burst_left = 0;
    ring_rd = '0;
    ring_wr = '0;
    free_cnt = '0;
    fresh_next = '0;
    pool_pages = '0;
    init_pages = INITIAL_PAGES_RST;
    for (int i = 0; i < MAX_PAGES; i++) page_prot[i] = PROT_READ_ONLY;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // above capacity first, then zero which acts as one page
    set_initial_pages(11'd2047);
    set_initial_pages(11'd0);

    // pool of one page, then doubling
    add_row(OP_ALLOC, 0,    1, 1, 0, 0,    1, 0, ST_OK);
    add_row(OP_ALLOC, 1023, 3, 1, 1, 4096, 1, 1, ST_OK);
    add_row(OP_FREE,  1023, 0, 1, 0, 0,    0, 0, ST_BAD_PAGE);
    add_row(OP_FREE,  2,    3, 1, 0, 0,    0, 0, ST_BAD_PAGE);
    add_row(OP_FREE,  1,    3, 1, 0, 0,    0, 0, ST_OK);
    add_row(OP_FREE,  0,    0, 1, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    2, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 511,  0, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    1, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    3, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    0, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_FREE,  4,    0, 0, 0, 0,    0, 0, ST_OK);
    // freeing the same page twice is queued twice
    add_row(OP_FREE,  4,    0, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_FREE,  3,    2, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    1, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    2, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    3, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    0, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    1, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    3, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 0,    2, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_FREE,  15,   1, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_FREE,  16,   1, 0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ALLOC, 1023, 3, 0, 0, 0,    0, 0, ST_OK);
    foreach (plan[i]) send_request(plan[i].req, plan[i].fixed, plan[i].res);

    repeat (60) begin
      pick_request(55, rq);
      send_request(rq, 1'b0, '0);
    end

    // no effect on the pool any more, still a legal write
    set_initial_pages(11'd1024);

    // run the pool to capacity and past it
    while (oop_hits < 5) begin
      pick_request(98, rq);
      send_request(rq, 1'b0, '0);
    end

    set_initial_pages(11'd1);

    idle_on = 1'b0;
    repeat (40) begin
      pick_request(50, rq);
      send_request(rq, 1'b0, '0);
    end
    idle_on = 1'b1;

    set_initial_pages(CFG_W'($urandom_range(0, 2047)));

    repeat (40) begin
      pick_request(50, rq);
      send_request(rq, 1'b0, '0);
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
